FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the range coalescer.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/arc_pkg.sv
// Package for the address range coalescer: widths, codes and shared types.
// No dependencies; used by arc_match and address_range_coalescer.
`default_nettype none

package arc_pkg;

  localparam int ADDR_W     = 16;
  localparam int BIT_LIM_W  = 11;
  localparam int REG_LIM_W  = 7;
  localparam int CFG_W      = 11;
  localparam int STATUS_W   = 3;
  localparam int TBL_W      = 2;
  localparam int NUM_TABLES = 4;

  localparam int MAX_RANGES_DEF = 16;

  // item kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_LIST = 1'b1;

  // config register indexes
  localparam logic CFG_BIT_LIMIT = 1'b0;
  localparam logic CFG_REG_LIMIT = 1'b1;

  localparam logic [BIT_LIM_W-1:0] BIT_LIMIT_RST = 11'd2000;
  localparam logic [REG_LIM_W-1:0] REG_LIMIT_RST = 7'd125;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_COVERED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WIDENED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LISTED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd6;

  // relation of an address to one stored range
  typedef struct packed {
    logic covered;    // first <= addr <= last
    logic at_limit;   // size == limit
    logic one_short;  // size == limit - 1
    logic below;      // addr + 1 == first
    logic above;      // addr == last + 1
  } match_t;

endpackage

`default_nettype wire

FILE: rtl/address_range_coalescer.sv
// Top level of the address range coalescer: sequencer, range memory, counts.
// Depends on arc_pkg, arc_match and assert_macros.svh.
`default_nettype none
// Usage
// - Input channel (in_valid / in_stall): one item is an add (in_kind = 0) of
//   in_address to table in_table_select, or a list (in_kind = 1) of a table.
//   in_stall is high while an item is being worked; one item at a time.
// - Result channel (out_valid / out_stall): an add gives one result; a list
//   gives one result per stored range (or one "table empty" result). out_last
//   marks the final result of an item. Results sit in an output register, so
//   a new item is taken while the last result still waits.
// - Config port: cfg_we writes cfg_wdata to register cfg_index (0 bit-table
//   limit, 1 register-table limit); write only while idle.
// - Sequencing: all tables live in one memory, one read and one write per
//   cycle, read data registered. An add reads and evaluates each entry it
//   scans (S_ADD_RD, S_ADD_EV); when it widens by the slow path, it then
//   reads and evaluates entries in a merge search and moves entries down
//   after a merge (search and move-down together cover at most n entries
//   of a table of n ranges). A list reads, evaluates and emits each range
//   in turn. A high out_stall holds a result in S_EMIT.
// - Reset (rst_n low at a clock edge): all tables empty, limits 2000 / 125.
//   The memory is not cleared; only entries below a table's count are read.
`include "assert_macros.svh"

module address_range_coalescer #(
  parameter int MAX_RANGES = arc_pkg::MAX_RANGES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_kind,
  input  wire logic [arc_pkg::TBL_W-1:0]        in_table_select,
  input  wire logic [arc_pkg::ADDR_W-1:0]       in_address,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [arc_pkg::STATUS_W-1:0]          out_status,
  output logic [arc_pkg::ADDR_W-1:0]            out_range_first,
  output logic [arc_pkg::ADDR_W-1:0]            out_range_last,
  output logic                                  out_last,
  // config port
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_index,
  input  wire logic [arc_pkg::CFG_W-1:0]        cfg_wdata
);
  import arc_pkg::*;

  localparam int IDX_W = $clog2(MAX_RANGES + 1);
  localparam int DEPTH = NUM_TABLES * MAX_RANGES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] CNT_FULL = IDX_W'(MAX_RANGES);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_LIST_RD = 10'b00_0000_0010,
    S_LIST_EV = 10'b00_0000_0100,
    S_ADD_RD  = 10'b00_0000_1000,
    S_ADD_EV  = 10'b00_0001_0000,
    S_MRG_RD  = 10'b00_0010_0000,
    S_MRG_EV  = 10'b00_0100_0000,
    S_SH_RD   = 10'b00_1000_0000,
    S_SH_EV   = 10'b01_0000_0000,
    S_EMIT    = 10'b10_0000_0000
  } state_t;

  state_t state_r;

  // item context
  logic [TBL_W-1:0]     tbl_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [BIT_LIM_W-1:0] lim_r;
  logic [IDX_W-1:0]     cnt_cur_r;
  logic [IDX_W-1:0]     idx_r;    // scan / list / merge / shift position
  logic [IDX_W-1:0]     hit_r;    // entry being widened
  logic                 dir_hi_r; // widened at its upper end
  logic [ADDR_W-1:0]    f_r;
  logic [ADDR_W-1:0]    e_r;
  logic                 list_more_r;

  // pending result
  logic [STATUS_W-1:0]  res_status_r;
  logic [ADDR_W-1:0]    res_first_r;
  logic [ADDR_W-1:0]    res_last_r;
  logic                 res_fin_r;

  // config and counts
  logic [BIT_LIM_W-1:0] bit_lim_r;
  logic [REG_LIM_W-1:0] reg_lim_r;
  logic [IDX_W-1:0]     cnt_r [NUM_TABLES];

  // output register
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [ADDR_W-1:0]    out_first_r;
  logic [ADDR_W-1:0]    out_last_addr_r;
  logic                 out_fin_r;
  logic                 out_free;

  // range memory
  logic [ADDR_W-1:0]    start_mem [DEPTH];
  logic [ADDR_W-1:0]    end_mem   [DEPTH];
  logic [ADDR_W-1:0]    rd_start_r;
  logic [ADDR_W-1:0]    rd_end_r;
  logic                 rd_en;
  logic [AW-1:0]        rd_idx;
  logic                 wr_en;
  logic [AW-1:0]        wr_idx;
  logic [ADDR_W-1:0]    wr_start;
  logic [ADDR_W-1:0]    wr_end;
  logic [AW-1:0]        mem_base;

  match_t               mt;
  logic                 merge_hit;

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_range_first = out_first_r;
  assign out_range_last  = out_last_addr_r;
  assign out_last        = out_fin_r;
  assign out_free        = !out_valid_r || !out_stall;

  assign mem_base = AW'(tbl_r) * AW'(MAX_RANGES);

  // the one compare unit, fed from the registered memory read
  arc_match u_match (
    .range_first (rd_start_r),
    .range_last  (rd_end_r),
    .address     (addr_r),
    .limit       (lim_r),
    .match       (mt)
  );

  // merge partner: low-side widening looks for a range ending just below,
  // high-side widening for one starting just above
  assign merge_hit = dir_hi_r ? mt.below : mt.above;

  // memory port control
  always_comb begin
    rd_en    = 1'b0;
    rd_idx   = mem_base + AW'(idx_r);
    wr_en    = 1'b0;
    wr_idx   = mem_base + AW'(hit_r);
    wr_start = dir_hi_r ? f_r : addr_r;
    wr_end   = dir_hi_r ? addr_r : e_r;
    case (state_r)
      S_LIST_RD: begin
        rd_en = 1'b1;
      end
      S_ADD_RD: begin
        if (idx_r != cnt_cur_r) begin
          rd_en = 1'b1;
        end else if (cnt_cur_r != CNT_FULL) begin
          // append a one-wide range
          wr_en    = 1'b1;
          wr_idx   = mem_base + AW'(cnt_cur_r);
          wr_start = addr_r;
          wr_end   = addr_r;
        end
      end
      S_ADD_EV: begin
        wr_idx   = mem_base + AW'(idx_r);
        wr_start = mt.below ? addr_r : rd_start_r;
        wr_end   = mt.below ? rd_end_r : addr_r;
        if (!mt.covered && !mt.at_limit && mt.one_short && (mt.below || mt.above)) begin
          wr_en = 1'b1;
        end
      end
      S_MRG_RD: begin
        // search done without partner: plain widening of the hit entry
        if (idx_r == cnt_cur_r) begin
          wr_en = 1'b1;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_MRG_EV: begin
        wr_start = dir_hi_r ? f_r : rd_start_r;
        wr_end   = dir_hi_r ? rd_end_r : e_r;
        if (merge_hit) begin
          wr_en = 1'b1;
        end
      end
      S_SH_RD: begin
        rd_idx = mem_base + AW'(idx_r) + AW'(1);
        if (idx_r + IDX_ONE != cnt_cur_r) begin
          rd_en = 1'b1;
        end
      end
      S_SH_EV: begin
        wr_en    = 1'b1;
        wr_idx   = mem_base + AW'(idx_r);
        wr_start = rd_start_r;
        wr_end   = rd_end_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[wr_idx] <= wr_start;
      end_mem[wr_idx]   <= wr_end;
    end
    if (rd_en) begin
      rd_start_r <= start_mem[rd_idx];
      rd_end_r   <= end_mem[rd_idx];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bit_lim_r   <= BIT_LIMIT_RST;
      reg_lim_r   <= REG_LIMIT_RST;
      for (int t = 0; t < NUM_TABLES; t++) begin
        cnt_r[t] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BIT_LIMIT: bit_lim_r <= cfg_wdata;
          CFG_REG_LIMIT: reg_lim_r <= cfg_wdata[REG_LIM_W-1:0];
          default: begin
          end
        endcase
      end

      // S_EMIT reloads the output register itself
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            tbl_r       <= in_table_select;
            addr_r      <= in_address;
            lim_r       <= in_table_select[1] ? BIT_LIM_W'(reg_lim_r) : bit_lim_r;
            cnt_cur_r   <= cnt_r[in_table_select];
            idx_r       <= '0;
            list_more_r <= 1'b0;
            res_fin_r   <= 1'b1;
            if (in_kind == KIND_LIST) begin
              if (cnt_r[in_table_select] == '0) begin
                res_status_r <= ST_EMPTY;
                res_first_r  <= '0;
                res_last_r   <= '0;
                state_r      <= S_EMIT;
              end else begin
                state_r <= S_LIST_RD;
              end
            end else begin
              state_r <= S_ADD_RD;
            end
          end
        end

        S_LIST_RD: state_r <= S_LIST_EV;

        S_LIST_EV: begin
          res_status_r <= ST_LISTED;
          res_first_r  <= rd_start_r;
          res_last_r   <= rd_end_r;
          res_fin_r    <= (idx_r + IDX_ONE == cnt_cur_r);
          list_more_r  <= (idx_r + IDX_ONE != cnt_cur_r);
          idx_r        <= idx_r + IDX_ONE;
          state_r      <= S_EMIT;
        end

        S_ADD_RD: begin
          if (idx_r != cnt_cur_r) begin
            state_r <= S_ADD_EV;
          end else begin
            if (cnt_cur_r != CNT_FULL) begin
              cnt_r[tbl_r] <= cnt_cur_r + IDX_ONE;
              res_status_r <= ST_APPENDED;
            end else begin
              res_status_r <= ST_DROPPED;
            end
            res_first_r <= addr_r;
            res_last_r  <= addr_r;
            state_r     <= S_EMIT;
          end
        end

        S_ADD_EV: begin
          if (mt.covered) begin
            res_status_r <= ST_COVERED;
            res_first_r  <= rd_start_r;
            res_last_r   <= rd_end_r;
            state_r      <= S_EMIT;
          end else if (mt.at_limit) begin
            idx_r   <= idx_r + IDX_ONE;
            state_r <= S_ADD_RD;
          end else if (mt.one_short) begin
            // widen without merge, or skip
            if (mt.below || mt.above) begin
              res_status_r <= ST_WIDENED;
              res_first_r  <= wr_start;
              res_last_r   <= wr_end;
              state_r      <= S_EMIT;
            end else begin
              idx_r   <= idx_r + IDX_ONE;
              state_r <= S_ADD_RD;
            end
          end else if (mt.below || mt.above) begin
            hit_r    <= idx_r;
            f_r      <= rd_start_r;
            e_r      <= rd_end_r;
            dir_hi_r <= !mt.below;
            idx_r    <= '0;
            state_r  <= S_MRG_RD;
          end else begin
            idx_r   <= idx_r + IDX_ONE;
            state_r <= S_ADD_RD;
          end
        end

        S_MRG_RD: begin
          if (idx_r == cnt_cur_r) begin
            res_status_r <= ST_WIDENED;
            res_first_r  <= wr_start;
            res_last_r   <= wr_end;
            state_r      <= S_EMIT;
          end else begin
            state_r <= S_MRG_EV;
          end
        end

        S_MRG_EV: begin
          if (merge_hit) begin
            // hit entry already rewritten; now drop the partner at idx_r
            res_status_r <= ST_MERGED;
            res_first_r  <= wr_start;
            res_last_r   <= wr_end;
            state_r      <= S_SH_RD;
          end else begin
            idx_r   <= idx_r + IDX_ONE;
            state_r <= S_MRG_RD;
          end
        end

        S_SH_RD: begin
          if (idx_r + IDX_ONE == cnt_cur_r) begin
            cnt_r[tbl_r] <= cnt_cur_r - IDX_ONE;
            state_r      <= S_EMIT;
          end else begin
            state_r <= S_SH_EV;
          end
        end

        S_SH_EV: begin
          idx_r   <= idx_r + IDX_ONE;
          state_r <= S_SH_RD;
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_status_r    <= res_status_r;
            out_first_r     <= res_first_r;
            out_last_addr_r <= res_last_r;
            out_fin_r       <= res_fin_r;
            state_r         <= list_more_r ? S_LIST_RD : S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CHK(a_only_list_open, clk, rst_n, (out_valid_r && !out_fin_r) |-> (out_status_r == ST_LISTED), "non-final result that is not a listed range")
  `ASSERT_CHK(a_shift_in_table, clk, rst_n, (state_r == S_SH_RD) |-> (idx_r < cnt_cur_r), "shift position past table end")
  `ASSERT_CHK(a_count_bound, clk, rst_n, (state_r != S_IDLE) |-> (cnt_cur_r <= CNT_FULL), "table count above capacity")
  `ASSERT_NEXT(a_emit_lands, clk, rst_n, (state_r == S_EMIT) && out_free, out_valid_r, "emitted result not presented")

endmodule

`default_nettype wire

FILE: rtl/arc_match.sv
// Range compare unit: relates one address to one stored range.
// Depends on arc_pkg. Shared by the scan and merge passes of the top level.
`default_nettype none

module arc_match (
  input  wire logic [arc_pkg::ADDR_W-1:0]    range_first,
  input  wire logic [arc_pkg::ADDR_W-1:0]    range_last,
  input  wire logic [arc_pkg::ADDR_W-1:0]    address,
  input  wire logic [arc_pkg::BIT_LIM_W-1:0] limit,
  output arc_pkg::match_t                    match
);
  import arc_pkg::*;

  // 17 bits: no wrap at the top of the address space
  logic [ADDR_W:0] last_p1;
  logic [ADDR_W:0] last_p2;
  logic [ADDR_W:0] first_lim;
  logic [ADDR_W:0] addr_p1;

  assign last_p1   = {1'b0, range_last} + (ADDR_W+1)'(1);
  assign last_p2   = {1'b0, range_last} + (ADDR_W+1)'(2);
  assign first_lim = {1'b0, range_first} + (ADDR_W+1)'(limit);
  assign addr_p1   = {1'b0, address} + (ADDR_W+1)'(1);

  always_comb begin
    match.covered   = (range_first <= address) && (address <= range_last);
    match.at_limit  = (last_p1 == first_lim);
    match.one_short = (last_p2 == first_lim);
    match.below     = (addr_p1 == {1'b0, range_first});
    match.above     = ({1'b0, address} == last_p1);
  end

endmodule

`default_nettype wire

FILE: tb/sv/address_range_coalescer_tb.sv
// Regression bench for address_range_coalescer: directed and random add/list items.
// A scoreboard class predicts every result; depends on arc_pkg and the block's RTL.
`timescale 1ns / 1ps

module address_range_coalescer_tb;
  import arc_pkg::*;

  localparam int MAX_RANGES  = MAX_RANGES_DEF;
  localparam int IDLE_LIMIT  = 2000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int END_SETTLE  = 120;   // wait after draining, before the final owed-results check

  // table codes
  localparam logic [TBL_W-1:0] TBL_COILS    = 2'd0;
  localparam logic [TBL_W-1:0] TBL_DISCRETE = 2'd1;
  localparam logic [TBL_W-1:0] TBL_HOLDING  = 2'd2;
  localparam logic [TBL_W-1:0] TBL_INPUT    = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   range_first;
    logic [ADDR_W-1:0]   range_last;
    logic                is_last;
  } range_result_t;

  // Range tables, limits and the queue of results still owed by the block.
  class coalescer_scoreboard;
    int unsigned   bit_limit;
    int unsigned   reg_limit;
    int unsigned   range_lo [NUM_TABLES][MAX_RANGES];
    int unsigned   range_hi [NUM_TABLES][MAX_RANGES];
    int unsigned   range_count [NUM_TABLES];
    range_result_t owed_q [$];
    int            errors;
    int            items_noted;
    int            results_checked;
    int            status_hits [7];

    function new();
      bit_limit = BIT_LIMIT_RST;
      reg_limit = REG_LIMIT_RST;
      foreach (range_count[t]) range_count[t] = 0;
      foreach (status_hits[s]) status_hits[s] = 0;
      errors = 0;
      items_noted = 0;
      results_checked = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void write_limit(logic idx, logic [CFG_W-1:0] value);
      if (idx == CFG_BIT_LIMIT) bit_limit = value[BIT_LIM_W-1:0];
      else reg_limit = value[REG_LIM_W-1:0];
    endfunction

    function void owe(logic [STATUS_W-1:0] st, int unsigned first, int unsigned lst,
                      logic fin);
      range_result_t r;
      r.status      = st;
      r.range_first = first[ADDR_W-1:0];
      r.range_last  = lst[ADDR_W-1:0];
      r.is_last     = fin;
      owed_q.push_back(r);
      status_hits[st]++;
    endfunction

    // close the gap left by a merged-away range
    function void drop_range(logic [TBL_W-1:0] t, int m);
      for (int k = m; k + 1 < int'(range_count[t]); k++) begin
        range_lo[t][k] = range_lo[t][k+1];
        range_hi[t][k] = range_hi[t][k+1];
      end
      range_count[t]--;
    endfunction

    function void add_address(logic [TBL_W-1:0] t, int unsigned a);
      int unsigned lim;
      int unsigned f;
      int unsigned e;
      int unsigned nb;
      int          n;
      int          hit;
      lim = (t == TBL_COILS || t == TBL_DISCRETE) ? bit_limit : reg_limit;
      n   = range_count[t];
      for (int j = 0; j < n; j++) begin
        f = range_lo[t][j];
        e = range_hi[t][j];
        if (f <= a && a <= e) begin
          owe(ST_COVERED, f, e, 1'b1);
          return;
        end else if (e + 1 == f + lim) begin
          continue;  // full size, look further
        end else if (e + 2 == f + lim) begin
          // last free slot: widen only, never merge
          if (a + 1 == f) begin
            range_lo[t][j] = a;
            owe(ST_WIDENED, a, e, 1'b1);
            return;
          end
          if (a == e + 1) begin
            range_hi[t][j] = a;
            owe(ST_WIDENED, f, a, 1'b1);
            return;
          end
        end else if (a + 1 == f) begin
          // grow down; a range ending right below the address is absorbed
          hit = -1;
          for (int m = 0; m < n; m++)
            if (a == range_hi[t][m] + 1) begin
              hit = m;
              break;
            end
          nb = (hit >= 0) ? range_lo[t][hit] : a;
          range_lo[t][j] = nb;
          if (hit >= 0) drop_range(t, hit);
          owe((hit >= 0) ? ST_MERGED : ST_WIDENED, nb, e, 1'b1);
          return;
        end else if (a == e + 1) begin
          // grow up; a range starting right above the address is absorbed
          hit = -1;
          for (int m = 0; m < n; m++)
            if (a + 1 == range_lo[t][m]) begin
              hit = m;
              break;
            end
          nb = (hit >= 0) ? range_hi[t][hit] : a;
          range_hi[t][j] = nb;
          if (hit >= 0) drop_range(t, hit);
          owe((hit >= 0) ? ST_MERGED : ST_WIDENED, f, nb, 1'b1);
          return;
        end
      end
      if (n < MAX_RANGES) begin
        range_lo[t][n] = a;
        range_hi[t][n] = a;
        range_count[t]++;
        owe(ST_APPENDED, a, a, 1'b1);
      end else begin
        owe(ST_DROPPED, a, a, 1'b1);
      end
    endfunction

    function void list_table(logic [TBL_W-1:0] t);
      int n;
      n = range_count[t];
      if (n == 0) owe(ST_EMPTY, 0, 0, 1'b1);
      for (int j = 0; j < n; j++)
        owe(ST_LISTED, range_lo[t][j], range_hi[t][j], (j + 1 == n));
    endfunction

    function void note_item(logic kind, logic [TBL_W-1:0] t, logic [ADDR_W-1:0] a);
      items_noted++;
      if (kind == KIND_ADD) add_address(t, a);
      else list_table(t);
    endfunction

    function void check_result(range_result_t got);
      range_result_t want;
      if (owed_q.size() == 0) begin
        $error("result with nothing owed: status %0d first %0d last %0d",
               got.status, got.range_first, got.range_last);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      results_checked++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.range_first !== want.range_first) begin
        $error("range_first: expected %0d, actual %0d", want.range_first, got.range_first);
        errors++;
      end
      if (got.range_last !== want.range_last) begin
        $error("range_last: expected %0d, actual %0d", want.range_last, got.range_last);
        errors++;
      end
      if (got.is_last !== want.is_last) begin
        $error("last: expected %0d, actual %0d", want.is_last, got.is_last);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_kind;
  logic [TBL_W-1:0]    in_table_select;
  logic [ADDR_W-1:0]   in_address;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_range_first;
  logic [ADDR_W-1:0]   out_range_last;
  logic                out_last;
  logic                cfg_we;
  logic                cfg_index;
  logic [CFG_W-1:0]    cfg_wdata;

  coalescer_scoreboard board;
  bit                  quiet;         // no idling on either side
  bit                  hold_request;  // ask the receiver for a long hold-off
  logic [ADDR_W-1:0]   window_base [NUM_TABLES];
  int                  window_span;

  address_range_coalescer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_table_select (in_table_select),
    .in_address      (in_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_range_first (out_range_first),
    .out_range_last  (out_range_last),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mostly zero or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Each window sits at the bottom, the top, or anywhere in the address space.
  function automatic void set_windows();
    for (int t = 0; t < NUM_TABLES; t++)
      case ($urandom_range(0, 3))
        0: window_base[t] = '0;
        1: window_base[t] = 16'hFFC0;
        default: window_base[t] = ADDR_W'($urandom());
      endcase
    window_span = $urandom_range(8, 48);
  endfunction

  // Result side: every accepted result goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(range_result_t'{out_status, out_range_first, out_range_last,
                                         out_last});
  end

  // Receiver back-pressure; the long hold-off is counted here.
  initial begin : result_sink
    int stall_left;
    out_stall  = 1'b0;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (quiet) begin
        out_stall = 1'b0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Give up when neither channel moves for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("address_range_coalescer regression: fail");
    $finish;
  end

  // Offer one item and return at the edge that takes it. Valid stays up so a
  // back-to-back item only swaps the payload at the next falling edge.
  task automatic drive_item(input logic kind, input logic [TBL_W-1:0] tsel,
                            input logic [ADDR_W-1:0] addr);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind         = kind;
    in_table_select = tsel;
    in_address      = addr;
    in_valid        = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(kind, tsel, addr);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    in_valid  = 1'b0;
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    board.write_limit(idx, data);
  endtask

  // Limits change only with nothing in flight.
  task automatic set_limits(input logic [CFG_W-1:0] bit_v, input logic [CFG_W-1:0] reg_v);
    wait_drained();
    cfg_write(CFG_BIT_LIMIT, bit_v);
    cfg_write(CFG_REG_LIMIT, reg_v);
  endtask

  // Random items: mostly adds clustered in a window so ranges grow and merge,
  // some spaced by two to fill tables, some anywhere, and lists.
  task automatic run_phase(input int n_items, input int hold_at, input int pause_at);
    int r;
    int t;
    set_windows();
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_request = 1'b1;
      if (i == pause_at) wait_drained();
      r = $urandom_range(0, 99);
      t = $urandom_range(0, NUM_TABLES - 1);
      if (r < 10)
        drive_item(KIND_LIST, TBL_W'(t), ADDR_W'($urandom()));
      else if (r < 18)
        drive_item(KIND_ADD, TBL_W'(t), ADDR_W'($urandom_range(0, 65535)));
      else if (r < 32)
        drive_item(KIND_ADD, TBL_W'(t),
                   ADDR_W'(window_base[t] + ADDR_W'(2 * $urandom_range(0, 20))));
      else
        drive_item(KIND_ADD, TBL_W'(t),
                   ADDR_W'(window_base[t] + ADDR_W'($urandom_range(0, window_span))));
    end
  endtask

  initial begin : stimulus
    board           = new();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = KIND_ADD;
    in_table_select = TBL_COILS;
    in_address      = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_BIT_LIMIT;
    cfg_wdata       = '0;
    quiet           = 1'b0;
    hold_request    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Coils at reset limits: empty list, both address edges (no wrap-around),
    // widening down and up, covered, then a widen that merges a neighbor.
    drive_item(KIND_LIST, TBL_COILS, 16'h0000);
    drive_item(KIND_ADD, TBL_COILS, 16'hFFFF);
    drive_item(KIND_ADD, TBL_COILS, 16'h0000);
    drive_item(KIND_ADD, TBL_COILS, 16'hFFFE);
    drive_item(KIND_ADD, TBL_COILS, 16'h0001);
    drive_item(KIND_ADD, TBL_COILS, 16'hFFFF);
    drive_item(KIND_ADD, TBL_COILS, 16'h0003);
    drive_item(KIND_ADD, TBL_COILS, 16'h0002);
    drive_item(KIND_LIST, TBL_COILS, 16'hFFFF);
    drive_item(KIND_ADD, TBL_HOLDING, 16'd100);
    drive_item(KIND_ADD, TBL_HOLDING, 16'd102);
    drive_item(KIND_ADD, TBL_HOLDING, 16'd101);
    drive_item(KIND_LIST, TBL_HOLDING, 16'h0000);

    // Register limit 2: one-short widen, a full range skipped, and a range
    // already past the limit still widening.
    set_limits(CFG_W'(2000), CFG_W'(2));
    drive_item(KIND_ADD, TBL_INPUT, 16'd10);
    drive_item(KIND_ADD, TBL_INPUT, 16'd11);
    drive_item(KIND_ADD, TBL_INPUT, 16'd12);
    drive_item(KIND_ADD, TBL_INPUT, 16'd9);
    drive_item(KIND_ADD, TBL_INPUT, 16'd13);
    drive_item(KIND_LIST, TBL_INPUT, 16'h0000);
    drive_item(KIND_ADD, TBL_HOLDING, 16'd103);

    // Bit limit 0: never full; neighbors widen, and one add merges two ranges.
    set_limits(CFG_W'(0), CFG_W'(2));
    drive_item(KIND_ADD, TBL_DISCRETE, 16'd5);
    drive_item(KIND_ADD, TBL_DISCRETE, 16'd6);
    drive_item(KIND_ADD, TBL_DISCRETE, 16'd8);
    drive_item(KIND_ADD, TBL_DISCRETE, 16'd7);
    drive_item(KIND_LIST, TBL_DISCRETE, 16'h0000);

    // Random phases; tables carry over, so later phases start from the ranges left by earlier ones.
    set_limits(CFG_W'(2000), CFG_W'(125));
    quiet = 1'b1;
    run_phase(34, -1, -1);
    quiet = 1'b0;
    set_limits(CFG_W'(1), CFG_W'(1));
    run_phase(34, -1, -1);
    set_limits(CFG_W'($urandom_range(2, 6)), CFG_W'($urandom_range(2, 6)));
    run_phase(36, 5, -1);   // receiver holds off, input backs up
    set_limits(CFG_W'(11'h7FF), CFG_W'(11'h7FF));
    run_phase(34, -1, 17);  // sender waits for every result mid-phase
    set_limits(CFG_W'(0), CFG_W'(0));
    run_phase(34, -1, -1);
    set_limits(CFG_W'($urandom_range(1, 2000)), CFG_W'($urandom_range(1, 125)));
    run_phase(34, -1, -1);

    wait_drained();
    repeat (END_SETTLE) @(negedge clk);
    if (board.pending() != 0) begin
      $error("%0d owed results never arrived", board.pending());
      board.errors++;
    end

    $display("covered %0d items and %0d results across eight limit settings",
             board.items_noted, board.results_checked);
    $display("status mix: covered %0d widened %0d merged %0d appended %0d dropped %0d",
             board.status_hits[ST_COVERED], board.status_hits[ST_WIDENED],
             board.status_hits[ST_MERGED], board.status_hits[ST_APPENDED],
             board.status_hits[ST_DROPPED]);
    if (board.errors == 0)
      $display("address_range_coalescer regression: pass");
    else
      $display("address_range_coalescer regression: fail");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/arc_pkg.sv
rtl/arc_match.sv
rtl/address_range_coalescer.sv
tb/sv/address_range_coalescer_tb.sv
